@@ hdl/bpg_pkg.sv @@
// shared types, constants and register codes for the blink pulse generator
`default_nettype none

package bpg_pkg;

    localparam int TIME_WIDTH = 16;
    localparam int CFG_TIME_WIDTH = 16;
    localparam int CMP_WIDTH = (TIME_WIDTH > CFG_TIME_WIDTH) ? TIME_WIDTH : CFG_TIME_WIDTH;
    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH = 2;

    typedef enum logic [2:0] {
        PH_STOP      = 3'd0,
        PH_RESTART   = 3'd1,
        PH_WAIT_EN   = 3'd2,
        PH_SWITCH_ON = 3'd3,
        PH_FEEDBACK  = 3'd4,
        PH_ON_TIME   = 3'd5,
        PH_OFF_TIME  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        CMD_BLINK = 2'd0,
        CMD_FORCE = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_ON_TIME       = 2'd0,
        REG_OFF_TIME      = 2'd1,
        REG_INVERT        = 2'd2,
        REG_FEEDBACK_USED = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_TIME_WIDTH-1:0] on_time;
        logic [CFG_TIME_WIDTH-1:0] off_time;
        logic                      invert;
        logic                      feedback_used;
    } cfg_t;

    typedef struct packed {
        cmd_t command;
        logic tick;
        logic blink_enable;
        logic feedback_level;
        logic set_value;
    } item_t;

    typedef struct packed {
        logic pin_level;
        logic line_on;
        logic on_event;
        logic off_event;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/bpg_cfg.sv @@
// apb register file holding the blink timing, polarity and feedback settings
`default_nettype none

module bpg_cfg (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [bpg_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [bpg_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [bpg_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                      pready,
    output bpg_pkg::cfg_t                             cfg
);
    import bpg_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_ON_TIME:       cfg_reg.on_time       <= pwdata[CFG_TIME_WIDTH-1:0];
                REG_OFF_TIME:      cfg_reg.off_time      <= pwdata[CFG_TIME_WIDTH-1:0];
                REG_INVERT:        cfg_reg.invert        <= pwdata[0];
                REG_FEEDBACK_USED: cfg_reg.feedback_used <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_ON_TIME:       prdata[CFG_TIME_WIDTH-1:0] = cfg_reg.on_time;
            REG_OFF_TIME:      prdata[CFG_TIME_WIDTH-1:0] = cfg_reg.off_time;
            REG_INVERT:        prdata[0] = cfg_reg.invert;
            REG_FEEDBACK_USED: prdata[0] = cfg_reg.feedback_used;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/bpg_core.sv @@
// blink phase sequencer: state registers and the one-pass step logic
`default_nettype none

module bpg_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire bpg_pkg::item_t   item,
    input  wire bpg_pkg::cfg_t    cfg,
    output bpg_pkg::result_t      result
);
    import bpg_pkg::*;

    phase_t                phase_reg, phase_next;
    logic                  triggered_reg, triggered_next;
    logic [TIME_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic                  level_reg, level_next;
    logic                  on_ev, off_ev, done;

    always_comb begin
        phase_next     = phase_reg;
        triggered_next = triggered_reg;
        elapsed_next   = elapsed_reg;
        level_next     = level_reg;
        on_ev          = 1'b0;
        off_ev         = 1'b0;
        done           = 1'b0;

        // saturating tick count
        if (item.tick && (elapsed_next != {TIME_WIDTH{1'b1}})) begin
            elapsed_next = elapsed_next + TIME_WIDTH'(1);
        end

        unique case (item.command)
            CMD_FORCE: begin
                level_next = item.set_value;
            end
            CMD_STOP: begin
                phase_next = PH_STOP;
            end
            CMD_NOP: begin
            end
            CMD_BLINK: begin
                if (phase_next == PH_STOP) begin
                    level_next = 1'b0;
                    phase_next = PH_RESTART;
                end
                // steady on / steady off override the cycle
                if (cfg.on_time == CFG_TIME_WIDTH'(1)) begin
                    level_next = 1'b1;
                    on_ev      = 1'b1;
                    done       = 1'b1;
                end else if (cfg.off_time == '0) begin
                    level_next = 1'b0;
                    off_ev     = 1'b1;
                    done       = 1'b1;
                end
                if (!done) begin
                    // phases fall through in order within one step
                    if (phase_next == PH_RESTART) begin
                        triggered_next = 1'b0;
                        phase_next     = PH_WAIT_EN;
                    end
                    if (phase_next == PH_WAIT_EN) begin
                        if (item.blink_enable) begin
                            triggered_next = 1'b1;
                        end
                        if (triggered_next) begin
                            phase_next = PH_SWITCH_ON;
                        end
                    end
                    if (phase_next == PH_SWITCH_ON) begin
                        level_next   = 1'b1;
                        on_ev        = 1'b1;
                        elapsed_next = '0;
                        phase_next   = PH_FEEDBACK;
                    end
                    if (phase_next == PH_FEEDBACK) begin
                        if (!cfg.feedback_used) begin
                            phase_next = PH_ON_TIME;
                        end else if (item.feedback_level) begin
                            elapsed_next = '0;
                            phase_next   = PH_ON_TIME;
                        end
                    end
                    if ((phase_next == PH_ON_TIME) &&
                        (CMP_WIDTH'(elapsed_next) >= CMP_WIDTH'(cfg.on_time))) begin
                        level_next   = 1'b0;
                        off_ev       = 1'b1;
                        elapsed_next = '0;
                        phase_next   = PH_OFF_TIME;
                    end
                    if ((phase_next == PH_OFF_TIME) &&
                        (CMP_WIDTH'(elapsed_next) >= CMP_WIDTH'(cfg.off_time))) begin
                        phase_next = PH_RESTART;
                    end
                end
            end
        endcase
    end

    always_comb begin
        result.pin_level = level_next ^ cfg.invert;
        result.line_on   = level_next;
        result.on_event  = on_ev;
        result.off_event = off_ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RESTART;
            triggered_reg <= 1'b0;
            elapsed_reg   <= '0;
            level_reg     <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            triggered_reg <= triggered_next;
            elapsed_reg   <= elapsed_next;
            level_reg     <= level_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/blink_pulse_generator_core.sv @@
// Blink pulse generator top level.
//
// Each word on the s_ channel is one step of an on/off blink timer for one
// output line: s_tuser carries the command (blink step, force level, stop, no-op),
// s_tdata the tick flag, enable, feedback level and forced value. Every
// accepted word produces exactly one word on the m_ channel with the driven
// pin level, the logical level and the on/off event pulses of that step.
// Timing and polarity are set through the APB port; write it only while the
// block holds no words in flight.
//
// A word accepted on the s_ channel sits in the input register, is stepped
// into the result register once that register is free, and is offered on
// m_tvalid from then on.
// Throughput: one word per cycle while m_tready is high; the step is a
// fixed short chain of phase checks and two timer compares between the
// input and result registers. When m_tready is low the result register
// holds, the input register fills, and s_tready drops until the result is
// taken; no word is lost. Reset clears the valid flags of both registers,
// the phase (to restart), the timer and the level, and all settings to zero.
`default_nettype none

module blink_pulse_generator_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // apb configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [bpg_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [bpg_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [bpg_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                      pready,
    // input words
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [7:0]                           s_tdata,  // tick, blink_enable,
                                                                // feedback_level, set_value, zeros
    input  wire logic [1:0]                           s_tuser,  // command
    // result words
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [7:0]                           m_tdata   // pin_level, line_on,
                                                                // on_event, off_event, zeros
);
    import bpg_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t step_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    bpg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.command        <= cmd_t'(s_tuser);
            in_item_reg.tick           <= s_tdata[0];
            in_item_reg.blink_enable   <= s_tdata[1];
            in_item_reg.feedback_level <= s_tdata[2];
            in_item_reg.set_value      <= s_tdata[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.off_event, out_res_reg.on_event,
                       out_res_reg.line_on, out_res_reg.pin_level};

endmodule

`default_nettype wire

@@ hdl/bpg_checker.sv @@
// port-level checks for the blink pulse generator and their binding
`default_nettype none

module bpg_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // result channel is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // an off event leaves the line off, also when paired with an on event
    a_off_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[1])
        else $error("off event with output on");

    // a lone on event leaves the line on
    a_on_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] && !m_tdata[3] |-> m_tdata[1])
        else $error("on event with output off");

endmodule

bind blink_pulse_generator_core bpg_checker u_bpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
